### hdl/wpm_pkg.sv
// Shared types and constants for the wildcard pattern matcher.
package wpm_pkg;

  // Request opcodes carried on the input channel.
  typedef enum logic [1:0] {
    OP_APPEND = 2'd0,
    OP_TEXT   = 2'd1,
    OP_END    = 2'd2,
    OP_CLEAR  = 2'd3
  } op_t;

  // Pattern bytes with a wildcard meaning.
  localparam logic [7:0] SYM_ANY  = 8'd63;
  localparam logic [7:0] SYM_STAR = 8'd42;

  // Command broadcast from the top level to every cell in the chain.
  typedef struct packed {
    logic       valid;
    op_t        op;
    logic [7:0] symbol;
  } cell_cmd_t;

endpackage

### hdl/wpm_if.sv
// Valid/ready channel interfaces for the matcher's request and result streams.
interface wpm_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] op;
  logic [7:0] symbol;

  modport source (output valid, output op, output symbol, input ready);
  modport sink   (input valid, input op, input symbol, output ready);
endinterface

interface wpm_out_if;
  logic valid;
  logic ready;
  logic matched;
  logic pattern_overflow;

  modport source (output valid, output matched, output pattern_overflow, input ready);
  modport sink   (input valid, input matched, input pattern_overflow, output ready);
endinterface

### hdl/wpm_cell.sv
// One pattern position: stored byte, occupancy flag and active bit.
module wpm_cell #(
  parameter int IDX         = 0,
  parameter int MAX_PATTERN = 32,
  parameter int LEN_W       = 6
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  wpm_pkg::cell_cmd_t    cmd,
  input  logic [LEN_W-1:0]      len,
  input  logic                  used_prev,
  input  logic                  shift_in,
  input  logic                  close_in,
  output logic                  shift_out,
  output logic                  close_out,
  output logic                  used_out,
  output logic                  hit
);

  // The last cell only holds the final position and never stores a byte.
  localparam bit LOADABLE = (IDX < MAX_PATTERN);
  localparam logic [LEN_W-1:0] IDX_L = LEN_W'(IDX);
  localparam bit IS_FIRST = (IDX == 0);

  logic       used_r, used_nxt;
  logic [7:0] char_r, char_nxt;
  logic       act_r, act_nxt;
  logic       star_n;
  logic       is_text;
  logic       raw;
  logic       closed;

  // Pattern storage update for append and clear requests.
  always_comb begin
    used_nxt = used_r;
    char_nxt = char_r;
    if (cmd.valid && cmd.op == wpm_pkg::OP_CLEAR) begin
      used_nxt = 1'b0;
    end else if (LOADABLE && cmd.valid && cmd.op == wpm_pkg::OP_APPEND && len == IDX_L) begin
      used_nxt = 1'b1;
      char_nxt = cmd.symbol;
    end
  end

  // A text byte moves activity forward; other requests reseed position zero.
  assign is_text   = cmd.valid && cmd.op == wpm_pkg::OP_TEXT;
  assign star_n    = used_nxt && char_nxt == wpm_pkg::SYM_STAR;
  assign shift_out = is_text && act_r && used_r &&
                     (char_r == wpm_pkg::SYM_ANY || char_r == cmd.symbol);
  assign raw       = is_text ? ((act_r && star_n) || shift_in) : IS_FIRST;

  // Star closure ripples to the neighbor like a carry.
  assign closed    = raw || close_in;
  assign close_out = closed && star_n;
  assign act_nxt   = cmd.valid ? closed : act_r;

  // This cell is the final position when it is empty and its predecessor is not.
  assign used_out = used_r;
  assign hit      = act_r && !used_r && used_prev;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r <= 1'b0;
      act_r  <= IS_FIRST;
    end else begin
      used_r <= used_nxt;
      act_r  <= act_nxt;
    end
  end

  // Pattern byte needs no reset.
  always_ff @(posedge clk) begin
    char_r <= char_nxt;
  end

endmodule

### hdl/wildcard_pattern_matcher.sv
// Top level of the wildcard pattern matcher: cell chain, length count and result stage.
//
// Usage: requests arrive on in_chan (op, symbol). OP_APPEND adds one pattern
// byte ('?' matches any byte, '*' any run), OP_CLEAR empties the pattern,
// OP_TEXT feeds one text byte and OP_END closes the text. Only OP_END yields
// a result on out_chan: matched tells whether the whole text matched the
// whole pattern, and pattern_overflow whether appended bytes were dropped
// because MAX_PATTERN positions were full. Append, clear and end of text all
// restart matching at the start of the pattern.
// Throughput: one request per cycle while the skid entry is empty. Each text byte updates every pattern
// position at once in a chain of MAX_PATTERN+1 cells; star closure ripples
// through the chain within the same cycle.
// Results: each OP_END result is registered in the result register, or in the skid entry while out_chan holds.
// Stall: a result register plus one skid entry hold results; in_chan.ready
// drops only while the skid entry is occupied.
// Reset: the pattern is empty, the overflow flag is clear and no result is
// pending; in_chan.ready is high as soon as reset is released.
module wildcard_pattern_matcher #(
  parameter int MAX_PATTERN = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  wpm_in_if.sink     in_chan,
  wpm_out_if.source  out_chan
);

  localparam int LEN_W = $clog2(MAX_PATTERN + 1);
  localparam int NCELL = MAX_PATTERN + 1;
  localparam logic [LEN_W-1:0] MAX_L = LEN_W'(MAX_PATTERN);

  wpm_pkg::cell_cmd_t cmd;
  logic               accept;
  logic               push;
  logic               take;

  logic [LEN_W-1:0]   len_r, len_nxt;
  logic               ovf_r, ovf_nxt;

  logic [NCELL:0]     shift_c;
  logic [NCELL:0]     close_c;
  logic [NCELL-1:0]   used_c;
  logic [NCELL-1:0]   hit_c;
  logic               matched_now;

  logic               out_valid_r, out_valid_nxt;
  logic               out_matched_r, out_ovf_r;
  logic               skid_valid_r, skid_valid_nxt;
  logic               skid_matched_r, skid_ovf_r;

  // Input handshake and command broadcast.
  assign in_chan.ready = !skid_valid_r;
  assign accept        = in_chan.valid && !skid_valid_r;
  assign cmd.valid     = accept;
  assign cmd.op        = wpm_pkg::op_t'(in_chan.op);
  assign cmd.symbol    = in_chan.symbol;

  // Pattern length and overflow flag.
  always_comb begin
    len_nxt = len_r;
    ovf_nxt = ovf_r;
    if (accept && cmd.op == wpm_pkg::OP_CLEAR) begin
      len_nxt = '0;
      ovf_nxt = 1'b0;
    end else if (accept && cmd.op == wpm_pkg::OP_APPEND) begin
      if (len_r < MAX_L) begin
        len_nxt = len_r + LEN_W'(1);
      end else begin
        ovf_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r <= '0;
      ovf_r <= 1'b0;
    end else begin
      len_r <= len_nxt;
      ovf_r <= ovf_nxt;
    end
  end

  // Chain of pattern-position cells.
  assign shift_c[0] = 1'b0;
  assign close_c[0] = 1'b0;

  for (genvar j = 0; j < NCELL; j++) begin : g_cell
    logic used_prev;
    if (j == 0) begin : g_head
      assign used_prev = 1'b1;
    end else begin : g_body
      assign used_prev = used_c[j-1];
    end

    wpm_cell #(
      .IDX         (j),
      .MAX_PATTERN (MAX_PATTERN),
      .LEN_W       (LEN_W)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .cmd       (cmd),
      .len       (len_r),
      .used_prev (used_prev),
      .shift_in  (shift_c[j]),
      .close_in  (close_c[j]),
      .shift_out (shift_c[j+1]),
      .close_out (close_c[j+1]),
      .used_out  (used_c[j]),
      .hit       (hit_c[j])
    );
  end

  // Exactly one cell marks the final position; its active bit is the answer.
  assign matched_now = |hit_c;

  // Result register with one skid entry.
  assign push = accept && cmd.op == wpm_pkg::OP_END;
  assign take = out_valid_r && out_chan.ready;

  assign out_valid_nxt  = skid_valid_r || push || (out_valid_r && !take);
  assign skid_valid_nxt = skid_valid_r ? !take : (push && out_valid_r && !take);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  // Result payload moves without reset.
  always_ff @(posedge clk) begin
    if (skid_valid_r && take) begin
      out_matched_r <= skid_matched_r;
      out_ovf_r     <= skid_ovf_r;
    end else if (push && (!out_valid_r || take)) begin
      out_matched_r <= matched_now;
      out_ovf_r     <= ovf_r;
    end
    if (push && out_valid_r && !take) begin
      skid_matched_r <= matched_now;
      skid_ovf_r     <= ovf_r;
    end
  end

  assign out_chan.valid            = out_valid_r;
  assign out_chan.matched          = out_matched_r;
  assign out_chan.pattern_overflow = out_ovf_r;

endmodule

### tb/sv/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the wildcard pattern matcher, with a bit-parallel match predictor.
module tb;

  localparam int MAX_PATTERN = 32;
  localparam int IDLE_LIMIT  = 2000;
  localparam int HOLD_CYCLES = 300;
  localparam int ITEM_TARGET = 1950;
  localparam logic [7:0] CHR_A = 8'h61;
  localparam logic [7:0] CHR_B = 8'h62;

  typedef struct packed {
    logic matched;
    logic overflow;
  } verdict_t;

  // Mirrors the pattern and the live positions and holds the verdicts still owed by the block.
  class match_tracker;
    logic [7:0]           pattern [MAX_PATTERN];
    int unsigned          pat_len;
    logic [MAX_PATTERN:0] live;
    logic                 overflow;
    verdict_t             pending_verdicts[$];
    int                   errors;

    function new();
      foreach (pattern[i]) pattern[i] = 8'h00;
      pat_len  = 0;
      overflow = 1'b0;
      errors   = 0;
      restart();
    endfunction

    // A live star position also makes the position after it live.
    function logic [MAX_PATTERN:0] close_stars(logic [MAX_PATTERN:0] set);
      for (int j = 0; j < pat_len; j++) begin
        if (set[j] && pattern[j] == wpm_pkg::SYM_STAR) set[j + 1] = 1'b1;
      end
      return set;
    endfunction

    function void restart();
      live    = '0;
      live[0] = 1'b1;
      live    = close_stars(live);
    endfunction

    // Moves every live position across one text byte.
    function void step_text(logic [7:0] c);
      logic [MAX_PATTERN:0] next;
      next = '0;
      for (int j = 0; j < pat_len; j++) begin
        if (live[j]) begin
          if (pattern[j] == wpm_pkg::SYM_STAR) next[j] = 1'b1;
          else if (pattern[j] == wpm_pkg::SYM_ANY || pattern[j] == c) next[j + 1] = 1'b1;
        end
      end
      live = close_stars(next);
    endfunction

    function void note_request(wpm_pkg::op_t op, logic [7:0] sym);
      verdict_t v;
      unique case (op)
        wpm_pkg::OP_APPEND: begin
          if (pat_len < MAX_PATTERN) begin
            pattern[pat_len] = sym;
            pat_len++;
          end else begin
            overflow = 1'b1;
          end
          restart();
        end
        wpm_pkg::OP_TEXT: step_text(sym);
        wpm_pkg::OP_END: begin
          v.matched  = live[pat_len];
          v.overflow = overflow;
          pending_verdicts.push_back(v);
          restart();
        end
        default: begin
          pat_len  = 0;
          overflow = 1'b0;
          restart();
        end
      endcase
    endfunction

    function void flag(string what);
      errors++;
      if (errors <= 10) $display("ERROR at %0t: %s", $time, what);
    endfunction

    function void check_verdict(logic m, logic o);
      verdict_t want;
      if (pending_verdicts.size() == 0) begin
        flag($sformatf("result with nothing expected: matched=%0b overflow=%0b", m, o));
        return;
      end
      want = pending_verdicts.pop_front();
      if (m !== want.matched)
        flag($sformatf("matched: expected %0b, got %0b", want.matched, m));
      if (o !== want.overflow)
        flag($sformatf("pattern_overflow: expected %0b, got %0b", want.overflow, o));
    endfunction
  endclass

  logic         clk = 1'b0;
  logic         rst_n;
  bit           hold_results;
  int           sent;
  int           burst_left;
  match_tracker book;

  wpm_in_if  in_if ();
  wpm_out_if out_if ();

  wildcard_pattern_matcher #(
    .MAX_PATTERN(MAX_PATTERN)
  ) dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_if),
    .out_chan(out_if)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Result side: stall patterns that change now and then, plus one long hold on request.
  initial begin
    int mode;
    int mode_left;
    int phase;
    out_if.ready = 1'b0;
    mode         = 0;
    mode_left    = 0;
    phase        = 0;
    forever begin
      @(negedge clk);
      if (hold_results) begin
        out_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_results = 1'b0;
      end
      if (mode_left == 0) begin
        mode      = $urandom_range(0, 3);
        mode_left = $urandom_range(20, 150);
      end
      mode_left--;
      phase++;
      unique case (mode)
        0:       out_if.ready <= 1'b1;
        1:       out_if.ready <= 1'($urandom_range(0, 1));
        2:       out_if.ready <= (phase % 4 == 0);
        default: out_if.ready <= ($urandom_range(0, 7) != 0);
      endcase
    end
  end

  // Check every accepted result against the oldest expected verdict.
  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready)
      book.check_verdict(out_if.matched, out_if.pattern_overflow);
  end

  // Watchdog: too many cycles in a row with no transfer on either channel ends the run.
  initial begin
    int idle;
    idle = 0;
    while (idle < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) idle = 0;
      else idle++;
    end
    $display("simulation failed");
    $finish;
  end

  // Holds one request until the block takes it; called and returns at a falling edge.
  task automatic push_request(wpm_pkg::op_t op, logic [7:0] sym);
    in_if.valid  <= 1'b1;
    in_if.op     <= op;
    in_if.symbol <= sym;
    do @(posedge clk); while (in_if.ready !== 1'b1);
    book.note_request(op, sym);
    sent++;
    @(negedge clk);
  endtask

  // Sends requests in bursts of random length with random gaps between them.
  task automatic offer(wpm_pkg::op_t op, logic [7:0] sym);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_if.valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 30);
    end
    burst_left--;
    push_request(op, sym);
  endtask

  // Stops sending until every expected verdict has come back.
  task automatic drain();
    in_if.valid <= 1'b0;
    do @(negedge clk); while (book.pending_verdicts.size() != 0);
  endtask

  // Pattern bytes lean toward a small alphabet and the two wildcards.
  function automatic logic [7:0] pat_byte();
    unique case ($urandom_range(0, 9))
      0, 1:    return CHR_A;
      2:       return CHR_B;
      3, 4:    return wpm_pkg::SYM_ANY;
      5, 6:    return wpm_pkg::SYM_STAR;
      default: return 8'($urandom);
    endcase
  endfunction

  // Text bytes include the wildcard codes, which carry no special meaning in text.
  function automatic logic [7:0] text_byte();
    unique case ($urandom_range(0, 9))
      0, 1, 2: return CHR_A;
      3:       return CHR_B;
      4:       return wpm_pkg::SYM_ANY;
      5:       return wpm_pkg::SYM_STAR;
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic load_pattern();
    int len;
    if ($urandom_range(0, 7) != 0) offer(wpm_pkg::OP_CLEAR, 8'($urandom));
    len = ($urandom_range(0, 11) == 0) ? $urandom_range(28, 40) : $urandom_range(0, 6);
    repeat (len) offer(wpm_pkg::OP_APPEND, pat_byte());
  endtask

  // One text closed by an end request: built to fit the pattern, fitted with one
  // byte disturbed, or random with an occasional pattern change mid-text.
  task automatic send_text(int style);
    int         spot;
    int         plen;
    logic [7:0] p;
    plen = book.pat_len;
    spot = (style == 1) ? $urandom_range(0, plen) : -1;
    if (style == 2) begin
      repeat ($urandom_range(0, 8)) begin
        if ($urandom_range(0, 9) == 0) offer(wpm_pkg::OP_APPEND, pat_byte());
        else offer(wpm_pkg::OP_TEXT, text_byte());
      end
    end else begin
      for (int j = 0; j < plen; j++) begin
        p = book.pattern[j];
        if (j == spot) begin
          if ($urandom_range(0, 1) == 1) offer(wpm_pkg::OP_TEXT, text_byte());
        end else if (p == wpm_pkg::SYM_STAR) begin
          repeat ($urandom_range(0, 3)) offer(wpm_pkg::OP_TEXT, text_byte());
        end else if (p == wpm_pkg::SYM_ANY) begin
          offer(wpm_pkg::OP_TEXT, 8'($urandom));
        end else begin
          offer(wpm_pkg::OP_TEXT, p);
        end
      end
      if (spot == plen) offer(wpm_pkg::OP_TEXT, text_byte());
    end
    offer(wpm_pkg::OP_END, 8'($urandom));
  endtask

  initial begin
    bit stalled_once;
    bit paused_once;
    int style;
    book         = new();
    rst_n        = 1'b0;
    in_if.valid  = 1'b0;
    in_if.op     = wpm_pkg::OP_APPEND;
    in_if.symbol = 8'h00;
    sent         = 0;
    burst_left   = 0;
    stalled_once = 1'b0;
    paused_once  = 1'b0;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;

    // Directed: empty pattern against empty and nonempty text.
    offer(wpm_pkg::OP_END, 8'hFF);
    offer(wpm_pkg::OP_TEXT, 8'h00);
    offer(wpm_pkg::OP_END, 8'h00);
    // A lone star matches the empty text and any text, wildcard codes included.
    offer(wpm_pkg::OP_APPEND, wpm_pkg::SYM_STAR);
    offer(wpm_pkg::OP_END, 8'h80);
    offer(wpm_pkg::OP_TEXT, 8'hFF);
    offer(wpm_pkg::OP_TEXT, wpm_pkg::SYM_STAR);
    offer(wpm_pkg::OP_TEXT, wpm_pkg::SYM_ANY);
    offer(wpm_pkg::OP_END, 8'h7F);
    // Star, any-byte and literal extremes together.
    offer(wpm_pkg::OP_APPEND, wpm_pkg::SYM_ANY);
    offer(wpm_pkg::OP_TEXT, 8'h80);
    offer(wpm_pkg::OP_END, 8'h01);
    offer(wpm_pkg::OP_APPEND, 8'hFF);
    offer(wpm_pkg::OP_TEXT, 8'h55);
    offer(wpm_pkg::OP_TEXT, 8'hFF);
    offer(wpm_pkg::OP_END, 8'hAA);
    // Appending mid-text throws away the text seen so far.
    offer(wpm_pkg::OP_TEXT, 8'h55);
    offer(wpm_pkg::OP_APPEND, 8'h00);
    offer(wpm_pkg::OP_TEXT, 8'h01);
    offer(wpm_pkg::OP_TEXT, 8'hFF);
    offer(wpm_pkg::OP_TEXT, 8'h00);
    offer(wpm_pkg::OP_END, 8'h00);
    // Clear, then a question mark in text against a wildcard in the pattern.
    offer(wpm_pkg::OP_CLEAR, 8'hFF);
    offer(wpm_pkg::OP_APPEND, wpm_pkg::SYM_ANY);
    offer(wpm_pkg::OP_TEXT, wpm_pkg::SYM_ANY);
    offer(wpm_pkg::OP_END, 8'hFF);

    // Random: mostly fitted sequences, some noise, one long result hold and one pause.
    while (sent < ITEM_TARGET) begin
      if ($urandom_range(0, 19) == 0) begin
        repeat ($urandom_range(1, 6)) offer(wpm_pkg::op_t'($urandom_range(0, 3)), 8'($urandom));
      end else begin
        load_pattern();
        repeat ($urandom_range(1, 4)) begin
          style = $urandom_range(0, 9);
          send_text(style < 5 ? 0 : (style < 8 ? 1 : 2));
        end
      end
      if (!stalled_once && sent > 600) begin
        stalled_once = 1'b1;
        hold_results = 1'b1;
        repeat (12) begin
          offer(wpm_pkg::OP_TEXT, text_byte());
          offer(wpm_pkg::OP_END, 8'($urandom));
        end
      end
      if (!paused_once && sent > 1200) begin
        paused_once = 1'b1;
        drain();
      end
    end

    drain();
    repeat (10) @(negedge clk);
    if (book.errors == 0 && book.pending_verdicts.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
